### rtl/i2c_eeprom_device_model_assert.svh
// ----------------------------------------------------------------------------
// i2c eeprom device model assertion macros
// concurrent assertion helpers clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_DEVICE_MODEL_ASSERT_SVH
`define I2C_EEPROM_DEVICE_MODEL_ASSERT_SVH

// property must hold at every clock edge outside reset
`define EE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define EE_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// shared types, request codes and defaults of the serial eeprom device model
// ----------------------------------------------------------------------------
package i2cee_pkg;

    // default geometry, both must be powers of two
    localparam int MEM_BYTES_DEF  = 256;
    localparam int PAGE_BYTES_DEF = 8;

    // field and register widths
    localparam int REQ_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int CAP_LOG2_W = 4;
    localparam int TIMER_W    = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;

    // capacity limits in log2 bytes
    localparam logic [CAP_LOG2_W-1:0] CAP_LOG2_MIN = 4'd3;
    localparam logic [CAP_LOG2_W-1:0] CAP_LOG2_MAX = 4'd8;

    // reset values
    localparam logic [CAP_LOG2_W-1:0] CAP_LOG2_RST = 4'd8;
    localparam logic [TIMER_W-1:0]    WR_TICKS_RST = 10'd5;
    localparam logic [BYTE_W-1:0]     ERASED_BYTE  = 8'hFF;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RD_RAND  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RD_CUR   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WR_ADDR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WR_CUR   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LOG2 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WR_TICKS = 1'd1;

    // input transaction
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] write_data;
        logic              end_of_burst;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              status;
        logic              busy_res;
    } out_item_t;

    // byte store command
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

### rtl/i2cee_store.sv
// ----------------------------------------------------------------------------
// i2cee_store
// byte store with registered read; unwritten bytes read as erased
// ----------------------------------------------------------------------------
module i2cee_store #(
    parameter int MEM_BYTES = i2cee_pkg::MEM_BYTES_DEF,
    parameter int ADDR_W    = $clog2(MEM_BYTES)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  i2cee_pkg::mem_cmd_t             cmd,
    input  logic [ADDR_W-1:0]               addr,
    input  logic [i2cee_pkg::BYTE_W-1:0]    wdata,
    output logic [i2cee_pkg::BYTE_W-1:0]    rdata
);

    logic [i2cee_pkg::BYTE_W-1:0] mem [MEM_BYTES];
    logic [MEM_BYTES-1:0]         written_reg;
    logic [i2cee_pkg::BYTE_W-1:0] rd_data_reg;
    logic                         rd_written_reg;

    // storage array and registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // written flags, cleared at reset so the store reads as erased
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
            begin
                written_reg[addr] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rd_written_reg <= written_reg[addr];
            end
        end
    end

    // erased bytes read back as all ones
    assign rdata = rd_written_reg ? rd_data_reg : i2cee_pkg::ERASED_BYTE;

endmodule

### rtl/i2c_eeprom_device_model.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_device_model
// transaction-level model of a small serial eeprom with page writes and a
// write-cycle busy timer
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready carry one request transaction (tick, random read,
//   current read, addressed write, write at counter); out_valid/out_ready
//   return exactly one result transaction per request, in order.
//   cfg_wr_en writes capacity_log2 (index 0) or write_cycle_ticks (index 1)
//   at once; write only while no request is in flight.
// result path
//   ticks, writes, refused and unknown requests: result registered in the cycle
//   after acceptance; the next request may follow in the next cycle.
//   accepted reads: the byte store has a registered read port, so the byte
//   goes through it and then the result register; in_ready stays low meanwhile.
// reset
//   store reads as erased (0xff) through per-byte written flags, counter and
//   timer are zero, capacity 2^8 bytes, write cycle 5 ticks; no clearing pass.
// stall
//   one result register sits on the output; a new request is taken, outside
//   S_READ, while the current result is taken, else in_ready drops till it drains.
//   MEM_BYTES and PAGE_BYTES must be powers of two.
// ----------------------------------------------------------------------------
module i2c_eeprom_device_model #(
    parameter int MEM_BYTES  = i2cee_pkg::MEM_BYTES_DEF,
    parameter int PAGE_BYTES = i2cee_pkg::PAGE_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [i2cee_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2cee_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  i2cee_pkg::in_item_t                in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output i2cee_pkg::out_item_t               out_data
);

    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);
    localparam int PAGE_LW   = (PAGE_LOG2 < ADDR_W) ? PAGE_LOG2 : ADDR_W;
    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((1 << PAGE_LW) - 1);
    localparam logic [i2cee_pkg::CAP_LOG2_W-1:0] MEM_LOG2 =
        i2cee_pkg::CAP_LOG2_W'(ADDR_W);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t                               state_reg, state_next;
    logic                                 out_valid_reg, out_valid_next;
    i2cee_pkg::out_item_t                 out_data_reg, out_data_next;
    logic [ADDR_W-1:0]                    ctr_reg, ctr_next;
    logic [i2cee_pkg::TIMER_W-1:0]        timer_reg, timer_next;
    logic [i2cee_pkg::CAP_LOG2_W-1:0]     cap_log2_reg, cap_log2_next;
    logic [i2cee_pkg::TIMER_W-1:0]        wr_ticks_reg, wr_ticks_next;

    logic [i2cee_pkg::CAP_LOG2_W-1:0]     lg_eff;
    logic [ADDR_W:0]                      cap_full;
    logic [ADDR_W-1:0]                    cap_mask;
    logic [ADDR_W-1:0]                    acc_addr;
    logic [ADDR_W-1:0]                    addr_inc;
    logic                                 in_fire;
    logic                                 busy;
    logic                                 use_field_addr;
    i2cee_pkg::mem_cmd_t                  mem_cmd;
    logic [i2cee_pkg::BYTE_W-1:0]         mem_rdata;
    logic                                 acc_req;
    logic                                 rd_start;
    logic                                 acc_refused;
    logic                                 acc_taken;

    // effective capacity: clamp log2 to the legal range and the store size
    always_comb
    begin
        lg_eff = cap_log2_reg;
        if (lg_eff < i2cee_pkg::CAP_LOG2_MIN)
        begin
            lg_eff = i2cee_pkg::CAP_LOG2_MIN;
        end
        if (lg_eff > i2cee_pkg::CAP_LOG2_MAX)
        begin
            lg_eff = i2cee_pkg::CAP_LOG2_MAX;
        end
        if (lg_eff > MEM_LOG2)
        begin
            lg_eff = MEM_LOG2;
        end
        cap_full = ((ADDR_W+1)'(1) << lg_eff) - (ADDR_W+1)'(1);
        cap_mask = cap_full[ADDR_W-1:0];
    end

    // access address and its increment
    assign in_fire        = in_valid && in_ready;
    assign busy           = (timer_reg != '0);
    assign use_field_addr = (in_data.req_type == i2cee_pkg::REQ_RD_RAND) ||
                            (in_data.req_type == i2cee_pkg::REQ_WR_ADDR);
    assign acc_addr       = (use_field_addr ? in_data.address[ADDR_W-1:0] : ctr_reg)
                            & cap_mask;
    assign addr_inc       = acc_addr + ADDR_W'(1);

    // request handling
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ctr_next       = ctr_reg;
        timer_next     = timer_reg;
        cap_log2_next  = cap_log2_reg;
        wr_ticks_next  = wr_ticks_reg;
        mem_cmd        = '0;

        // configuration writes
        if (cfg_wr_en)
        begin
            case (cfg_index)
                i2cee_pkg::CFG_CAP_LOG2: cap_log2_next = cfg_data[i2cee_pkg::CAP_LOG2_W-1:0];
                i2cee_pkg::CFG_WR_TICKS: wr_ticks_next = cfg_data[i2cee_pkg::TIMER_W-1:0];
                default: ;
            endcase
        end

        // result taken by the receiver
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.read_data = '0;
                    out_data_next.status    = 1'b0;
                    case (in_data.req_type)
                        i2cee_pkg::REQ_TICK:
                        begin
                            if (busy)
                            begin
                                timer_next = timer_reg - i2cee_pkg::TIMER_W'(1);
                            end
                        end
                        i2cee_pkg::REQ_RD_RAND, i2cee_pkg::REQ_RD_CUR:
                        begin
                            if (busy)
                            begin
                                out_data_next.status = 1'b1;
                            end
                            else
                            begin
                                mem_cmd.rd     = 1'b1;
                                ctr_next       = addr_inc & cap_mask;
                                out_valid_next = 1'b0;
                                state_next     = S_READ;
                            end
                        end
                        i2cee_pkg::REQ_WR_ADDR, i2cee_pkg::REQ_WR_CUR:
                        begin
                            if (busy)
                            begin
                                out_data_next.status = 1'b1;
                            end
                            else
                            begin
                                mem_cmd.wr = 1'b1;
                                ctr_next   = ((acc_addr & ~PAGE_MASK) | (addr_inc & PAGE_MASK))
                                             & cap_mask;
                                if (in_data.end_of_burst)
                                begin
                                    timer_next = wr_ticks_reg;
                                end
                            end
                        end
                        default: ;
                    endcase
                    out_data_next.busy_res = (timer_next != '0);
                end
            end
            S_READ:
            begin
                // read data is back from the store, timer is idle here
                out_valid_next          = 1'b1;
                out_data_next.read_data = mem_rdata;
                out_data_next.status    = 1'b0;
                out_data_next.busy_res  = 1'b0;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            ctr_reg       <= '0;
            timer_reg     <= '0;
            cap_log2_reg  <= i2cee_pkg::CAP_LOG2_RST;
            wr_ticks_reg  <= i2cee_pkg::WR_TICKS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            ctr_reg       <= ctr_next;
            timer_reg     <= timer_next;
            cap_log2_reg  <= cap_log2_next;
            wr_ticks_reg  <= wr_ticks_next;
        end
    end

    // byte store
    i2cee_store #(
        .MEM_BYTES (MEM_BYTES),
        .ADDR_W    (ADDR_W)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mem_cmd),
        .addr  (acc_addr),
        .wdata (in_data.write_data),
        .rdata (mem_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // request classes seen by the checks
    assign acc_req     = (in_data.req_type != i2cee_pkg::REQ_TICK) &&
                         (in_data.req_type <= i2cee_pkg::REQ_WR_CUR);
    assign rd_start    = in_fire && !busy &&
                         ((in_data.req_type == i2cee_pkg::REQ_RD_RAND) ||
                          (in_data.req_type == i2cee_pkg::REQ_RD_CUR));
    assign acc_refused = in_fire && busy && acc_req;
    assign acc_taken   = in_fire && !busy && acc_req;

    // checks
    `include "i2c_eeprom_device_model_assert.svh"

    `EE_NEVER(a_read_slot_free, (state_reg == S_READ) && out_valid_reg, "read slot occupied")
    `EE_ASSERT(a_read_wait, rd_start |=> (state_reg == S_READ), "read did not wait for store")
    `EE_ASSERT(a_busy_refuse, acc_refused |=> out_data_reg.status, "busy access not refused")
    `EE_ASSERT(a_busy_hold, acc_refused |=> $stable(ctr_reg), "busy access moved counter")
    `EE_ASSERT(a_ctr_in_cap, acc_taken |=> ((ctr_reg & ~$past(cap_mask)) == '0), "ctr beyond cap")

endmodule

### test/i2c_eeprom_device_model_tb.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_device_model_tb
// self-checking bench for the serial eeprom model: a directed table (erased
// reads, extremes, page wrap, busy refusal, tick countdown, undefined
// requests) followed by random write bursts, read runs, ticks and noise over
// several capacity and write-cycle settings, mostly with random idling on both sides
// ----------------------------------------------------------------------------
module i2c_eeprom_device_model_tb;

    localparam int MEM_BYTES  = i2cee_pkg::MEM_BYTES_DEF;
    localparam int PAGE_BYTES = i2cee_pkg::PAGE_BYTES_DEF;
    localparam int ADDR_W     = $clog2(MEM_BYTES);

    // request codes with no function in the device
    localparam logic [i2cee_pkg::REQ_W-1:0] REQ_UNDEF_LO = 3'd5;
    localparam logic [i2cee_pkg::REQ_W-1:0] REQ_UNDEF_HI = 3'd7;

    // result status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    // cycles without any transaction before the run is declared hung
    localparam int HANG_LIMIT = 2000;

    // configuration phases of the random part
    localparam int NUM_PHASES   = 7;
    localparam int PH_MID_DRAIN = 4;
    localparam int PH_CAP   [NUM_PHASES] = '{3, 0, 15, 5, 8, 6, 7};
    localparam int PH_TICKS [NUM_PHASES] = '{0, 2, 1, 3, 7, 4, 1023};
    localparam int PH_ITEMS [NUM_PHASES] = '{150, 100, 150, 150, 200, 130, 60};
    localparam bit PH_IDLE  [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

    typedef struct packed {
        i2cee_pkg::in_item_t  item;
        logic                 fixed;
        i2cee_pkg::out_item_t res;
    } dir_row_t;

    // directed table, starting from reset: capacity 256, write cycle 5 ticks
    localparam int NUM_DIR = 25;
    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        '{'{i2cee_pkg::REQ_RD_RAND, 8'h00, 8'h00, 1'b0}, 1'b1, '{8'hFF, ST_OK,   1'b0}},
        '{'{i2cee_pkg::REQ_RD_RAND, 8'hFF, 8'h00, 1'b0}, 1'b1, '{8'hFF, ST_OK,   1'b0}},
        '{'{i2cee_pkg::REQ_RD_CUR,  8'h00, 8'h00, 1'b0}, 1'b1, '{8'hFF, ST_OK,   1'b0}},
        '{'{i2cee_pkg::REQ_WR_ADDR, 8'hFF, 8'h00, 1'b0}, 1'b1, '{8'h00, ST_OK,   1'b0}},
        '{'{i2cee_pkg::REQ_WR_CUR,  8'h00, 8'hAA, 1'b0}, 1'b1, '{8'h00, ST_OK,   1'b0}},
        '{'{i2cee_pkg::REQ_RD_RAND, 8'hFF, 8'h00, 1'b0}, 1'b1, '{8'h00, ST_OK,   1'b0}},
        '{'{i2cee_pkg::REQ_RD_RAND, 8'hF8, 8'h00, 1'b0}, 1'b1, '{8'hAA, ST_OK,   1'b0}},
        '{'{i2cee_pkg::REQ_WR_ADDR, 8'h07, 8'h5A, 1'b1}, 1'b1, '{8'h00, ST_OK,   1'b1}},
        '{'{i2cee_pkg::REQ_RD_RAND, 8'h07, 8'h00, 1'b0}, 1'b1, '{8'h00, ST_BUSY, 1'b1}},
        '{'{i2cee_pkg::REQ_WR_CUR,  8'h00, 8'h11, 1'b1}, 1'b1, '{8'h00, ST_BUSY, 1'b1}},
        '{'{i2cee_pkg::REQ_RD_CUR,  8'h00, 8'h00, 1'b0}, 1'b1, '{8'h00, ST_BUSY, 1'b1}},
        '{'{i2cee_pkg::REQ_WR_ADDR, 8'h00, 8'h22, 1'b0}, 1'b1, '{8'h00, ST_BUSY, 1'b1}},
        '{'{i2cee_pkg::REQ_TICK,    8'h00, 8'h00, 1'b0}, 1'b1, '{8'h00, ST_OK,   1'b1}},
        '{'{i2cee_pkg::REQ_TICK,    8'hFF, 8'hFF, 1'b1}, 1'b1, '{8'h00, ST_OK,   1'b1}},
        '{'{i2cee_pkg::REQ_TICK,    8'h00, 8'h00, 1'b0}, 1'b1, '{8'h00, ST_OK,   1'b1}},
        '{'{i2cee_pkg::REQ_TICK,    8'h00, 8'h00, 1'b0}, 1'b1, '{8'h00, ST_OK,   1'b1}},
        '{'{i2cee_pkg::REQ_TICK,    8'h00, 8'h00, 1'b0}, 1'b1, '{8'h00, ST_OK,   1'b0}},
        '{'{i2cee_pkg::REQ_TICK,    8'h00, 8'h00, 1'b0}, 1'b1, '{8'h00, ST_OK,   1'b0}},
        '{'{REQ_UNDEF_HI,           8'hFF, 8'hFF, 1'b1}, 1'b1, '{8'h00, ST_OK,   1'b0}},
        '{'{REQ_UNDEF_LO,           8'h07, 8'h00, 1'b0}, 1'b1, '{8'h00, ST_OK,   1'b0}},
        '{'{i2cee_pkg::REQ_RD_CUR,  8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{i2cee_pkg::REQ_RD_RAND, 8'h07, 8'h00, 1'b1}, 1'b1, '{8'h5A, ST_OK,   1'b0}},
        '{'{i2cee_pkg::REQ_WR_CUR,  8'h00, 8'h33, 1'b0}, 1'b0, '0},
        '{'{i2cee_pkg::REQ_RD_RAND, 8'h08, 8'h00, 1'b0}, 1'b0, '0},
        '{'{i2cee_pkg::REQ_RD_CUR,  8'h00, 8'h00, 1'b0}, 1'b0, '0}
    };

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [i2cee_pkg::CFG_IDX_W-1:0]  cfg_index = i2cee_pkg::CFG_CAP_LOG2;
    logic [i2cee_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    i2cee_pkg::in_item_t              in_data = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    i2cee_pkg::out_item_t             out_data;

    // predicted device state
    logic [i2cee_pkg::BYTE_W-1:0]     ee_store [MEM_BYTES];
    int                               ee_counter;
    int                               ee_timer;
    logic [i2cee_pkg::CAP_LOG2_W-1:0] ee_cap_log2;
    logic [i2cee_pkg::TIMER_W-1:0]    ee_wr_ticks;

    i2cee_pkg::out_item_t pending_results [$];
    int                   items_sent = 0;
    int                   fail_cnt = 0;
    int                   shown_cnt = 0;
    int                   idle_cycles = 0;
    int                   rx_hold = 0;
    bit                   tx_idle_on = 1'b0;
    bit                   rx_idle_on = 1'b0;

    i2c_eeprom_device_model dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // random field values
    function automatic logic [i2cee_pkg::BYTE_W-1:0] rand_byte();
        return i2cee_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [i2cee_pkg::REQ_W-1:0] rand_req(logic [i2cee_pkg::REQ_W-1:0] lo,
                                                            logic [i2cee_pkg::REQ_W-1:0] hi);
        return i2cee_pkg::REQ_W'($urandom_range(int'(lo), int'(hi)));
    endfunction

    function automatic i2cee_pkg::in_item_t make_item(logic [i2cee_pkg::REQ_W-1:0] req,
                                                      logic [i2cee_pkg::BYTE_W-1:0] addr,
                                                      logic [i2cee_pkg::BYTE_W-1:0] data,
                                                      logic eob);
        i2cee_pkg::in_item_t t;
        t.req_type     = req;
        t.address      = addr;
        t.write_data   = data;
        t.end_of_burst = eob;
        return t;
    endfunction

    // applies one request to the predicted state and returns its result
    function automatic i2cee_pkg::out_item_t eeprom_predict(i2cee_pkg::in_item_t t);
        i2cee_pkg::out_item_t r;
        int                   lg;
        int                   cap;
        int                   a;
        r  = '0;
        lg = int'(ee_cap_log2);
        if (lg < int'(i2cee_pkg::CAP_LOG2_MIN))
            lg = int'(i2cee_pkg::CAP_LOG2_MIN);
        if (lg > int'(i2cee_pkg::CAP_LOG2_MAX))
            lg = int'(i2cee_pkg::CAP_LOG2_MAX);
        cap = 1 << lg;
        if (cap > MEM_BYTES)
            cap = MEM_BYTES;
        case (t.req_type)
            i2cee_pkg::REQ_TICK:
            begin
                if (ee_timer != 0)
                    ee_timer--;
            end
            i2cee_pkg::REQ_RD_RAND, i2cee_pkg::REQ_RD_CUR,
            i2cee_pkg::REQ_WR_ADDR, i2cee_pkg::REQ_WR_CUR:
            begin
                if (ee_timer != 0)
                    r.status = ST_BUSY;
                else
                begin
                    if (t.req_type == i2cee_pkg::REQ_RD_RAND ||
                        t.req_type == i2cee_pkg::REQ_WR_ADDR)
                        a = int'(t.address) % cap;
                    else
                        a = ee_counter % cap;
                    if (t.req_type == i2cee_pkg::REQ_RD_RAND ||
                        t.req_type == i2cee_pkg::REQ_RD_CUR)
                    begin
                        r.read_data = ee_store[ADDR_W'(a)];
                        ee_counter  = (a + 1) % cap;
                    end
                    else
                    begin
                        // counter rolls over within the page
                        ee_store[ADDR_W'(a)] = t.write_data;
                        ee_counter  = (a - a % PAGE_BYTES + (a + 1) % PAGE_BYTES) % cap;
                        if (t.end_of_burst)
                            ee_timer = int'(ee_wr_ticks);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.busy_res = (ee_timer != 0);
        return r;
    endfunction

    // one request transaction, optionally after a random gap
    task automatic send_item(i2cee_pkg::in_item_t t, logic fixed,
                             i2cee_pkg::out_item_t fixed_res);
        int                   gap;
        i2cee_pkg::out_item_t guess;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 2) == 0)
            gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (!in_ready);
        guess = eeprom_predict(t);
        pending_results.push_back(fixed ? fixed_res : guess);
        items_sent++;
    endtask

    // stop sending until every result is back and the read path has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(int cap_log2, int wr_ticks);
        cfg_wr_en <= 1'b1;
        cfg_index <= i2cee_pkg::CFG_CAP_LOG2;
        cfg_data  <= i2cee_pkg::CFG_DATA_W'(cap_log2);
        @(posedge clk);
        cfg_index <= i2cee_pkg::CFG_WR_TICKS;
        cfg_data  <= i2cee_pkg::CFG_DATA_W'(wr_ticks);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        ee_cap_log2 = i2cee_pkg::CAP_LOG2_W'(cap_log2);
        ee_wr_ticks = i2cee_pkg::TIMER_W'(wr_ticks);
    endtask

    // addressed write followed by writes at the counter, maybe wrapping within the page
    task automatic write_burst();
        int   k;
        logic eob_last;
        k        = $urandom_range(0, 9);
        eob_last = ($urandom_range(0, 99) < 85);
        send_item(make_item(i2cee_pkg::REQ_WR_ADDR, rand_byte(), rand_byte(),
                            (k == 0) ? eob_last : 1'b0), 1'b0, '0);
        for (int i = 1; i <= k; i++)
            send_item(make_item(i2cee_pkg::REQ_WR_CUR, rand_byte(), rand_byte(),
                                (i == k) ? eob_last : 1'b0), 1'b0, '0);
    endtask

    // random read followed by sequential reads
    task automatic read_run();
        int k;
        k = $urandom_range(0, 12);
        send_item(make_item(i2cee_pkg::REQ_RD_RAND, rand_byte(), rand_byte(), rand_bit()),
                  1'b0, '0);
        for (int i = 0; i < k; i++)
            send_item(make_item(i2cee_pkg::REQ_RD_CUR, rand_byte(), rand_byte(), rand_bit()),
                      1'b0, '0);
    endtask

    task automatic run_phase(int n, bit mid_drain);
        int start;
        int r;
        bit drained;
        start   = items_sent;
        drained = 1'b0;
        while (items_sent - start < n)
        begin
            if (mid_drain && !drained && items_sent - start >= n / 2)
            begin
                wait_drained();
                drained = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (ee_timer != 0)
            begin
                // mostly count the write cycle down, sometimes poke a busy device
                if (r < 80)
                    send_item(make_item(i2cee_pkg::REQ_TICK, rand_byte(), rand_byte(),
                                        rand_bit()), 1'b0, '0);
                else
                    send_item(make_item(rand_req(i2cee_pkg::REQ_RD_RAND, i2cee_pkg::REQ_WR_CUR),
                                        rand_byte(), rand_byte(), rand_bit()), 1'b0, '0);
            end
            else if (r < 35)
                write_burst();
            else if (r < 65)
                read_run();
            else if (r < 75)
                send_item(make_item(i2cee_pkg::REQ_TICK, 8'h00, 8'h00, 1'b0), 1'b0, '0);
            else if (r < 90)
                send_item(make_item($urandom_range(0, 1) ? i2cee_pkg::REQ_RD_CUR
                                                         : i2cee_pkg::REQ_WR_CUR,
                                    rand_byte(), rand_byte(), rand_bit()), 1'b0, '0);
            else
                send_item(make_item(rand_req(i2cee_pkg::REQ_TICK, REQ_UNDEF_HI),
                                    rand_byte(), rand_byte(), rand_bit()), 1'b0, '0);
        end
    endtask

    // result side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold   <= 0;
        end
        else if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 3) == 0)
                rx_hold <= idle_len();
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        i2cee_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_cnt++;
                if (shown_cnt < 10)
                    $display("unexpected result: read_data %h status %b busy %b",
                             out_data.read_data, out_data.status, out_data.busy_res);
                shown_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.read_data !== want.read_data || out_data.status !== want.status
                    || out_data.busy_res !== want.busy_res)
                begin
                    fail_cnt++;
                    if (shown_cnt < 10)
                        $display("mismatch: exp read_data %h status %b busy %b, got %h %b %b",
                                 want.read_data, want.status, want.busy_res,
                                 out_data.read_data, out_data.status, out_data.busy_res);
                    shown_cnt++;
                end
            end
        end
    end

    // hang detection
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < HANG_LIMIT)
            @(posedge clk);
        $display("i2c_eeprom_device_model_tb: FAIL");
        $finish;
    end

    // main sequence
    initial
    begin
        for (int i = 0; i < MEM_BYTES; i++)
            ee_store[ADDR_W'(i)] = i2cee_pkg::ERASED_BYTE;
        ee_counter  = 0;
        ee_timer    = 0;
        ee_cap_log2 = i2cee_pkg::CAP_LOG2_RST;
        ee_wr_ticks = i2cee_pkg::WR_TICKS_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int i = 0; i < NUM_DIR; i++)
            send_item(DIR_ROWS[i].item, DIR_ROWS[i].fixed, DIR_ROWS[i].res);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            set_config(PH_CAP[ph], PH_TICKS[ph]);
            tx_idle_on = PH_IDLE[ph];
            rx_idle_on = PH_IDLE[ph];
            run_phase(PH_ITEMS[ph], ph == PH_MID_DRAIN);
        end
        wait_drained();

        if (fail_cnt == 0)
            $display("i2c_eeprom_device_model_tb: PASS");
        else
            $display("i2c_eeprom_device_model_tb: FAIL");
        $finish;
    end

endmodule
